FILE: rtl/keyed_first_free_slot_allocator_assert.svh
// Assertion macros for the keyed first-free slot allocator.
`ifndef KEYED_FIRST_FREE_SLOT_ALLOCATOR_ASSERT_SVH
`define KEYED_FIRST_FREE_SLOT_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define KFFSA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("kffsa assertion failed");
// Check that a condition never holds outside reset.
`define KFFSA_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("kffsa forbidden condition seen");
`else
`define KFFSA_ASSERT(name, clk, rst_n, prop)
`define KFFSA_NEVER(name, clk, rst_n, cond)
`endif
`endif

FILE: rtl/kffsa_pkg.sv
// Shared types and constants of the keyed first-free slot allocator.
package kffsa_pkg;

  localparam int unsigned KEY_W      = 64;
  localparam int unsigned SLOT_NUM_W = 7;
  localparam int unsigned ACTIVE_W   = 7;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_DUP     = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_MISSING = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic                  vld;
    logic                  hit;
    logic [SLOT_NUM_W-1:0] hit_num;
    logic                  free;
    logic [SLOT_NUM_W-1:0] free_num;
  } tok_t;

  // Update broadcast to all cells at the end of a search.
  typedef struct packed {
    logic                  set;
    logic                  clr;
    logic [SLOT_NUM_W-1:0] num;
  } cmd_t;

endpackage

FILE: rtl/kffsa_cell.sv
// One slot of the allocator: occupancy, key and one stage of the search chain.
module kffsa_cell #(
  parameter int INDEX = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [kffsa_pkg::KEY_W-1:0]  key_i,
  input  kffsa_pkg::tok_t              tok_i,
  input  kffsa_pkg::cmd_t              cmd_i,
  output kffsa_pkg::tok_t              tok_o
);

  localparam int unsigned NW = kffsa_pkg::SLOT_NUM_W;
  localparam logic [NW-1:0] NUM = NW'(INDEX + 1);
  // Slots past the numbering range can never be claimed, so never address them.
  localparam bit ADDRESSABLE = (INDEX + 1) < (2 ** NW);

  logic                        busy_q;
  logic [kffsa_pkg::KEY_W-1:0] key_q;
  kffsa_pkg::tok_t             tok_d, tok_q;
  logic                        match, is_free, sel;

  assign match   = busy_q && (key_q == key_i);
  assign is_free = en_i && !busy_q;
  assign sel     = ADDRESSABLE && (cmd_i.num == NUM);

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && !tok_i.hit && match) begin
      tok_d.hit     = 1'b1;
      tok_d.hit_num = NUM;
    end
    if (tok_i.vld && !tok_i.free && is_free) begin
      tok_d.free     = 1'b1;
      tok_d.free_num = NUM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (sel && cmd_i.set) begin
      busy_q <= 1'b1;
    end else if (sel && cmd_i.clr) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel && cmd_i.set) begin
      key_q <= key_i;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: rtl/keyed_first_free_slot_allocator.sv
// Top level of the keyed first-free slot allocator.
//
// Usage:
// - Request channel: in_valid_i / in_stall_o with opcode_i (0 allocate,
//   1 release) and a 64-bit item_key_i. An item is taken on a clock edge
//   with in_valid_i high and in_stall_o low.
// - Response channel: out_valid_o / out_stall_i with status_o and
//   slot_number_o (1-based, 0 on any failure).
// - cfg_we_i / cfg_wdata_i write active_slots; write it only while idle.
// - A search token walks the row of slot cells, one cell per cycle.
//   One request is in flight at a time: the next item is taken only
//   after the current response has been loaded into the output register.
// - A finished response sits in the output register; the next request is
//   accepted and searched while it waits. If the receiver stalls longer,
//   the next response holds in its own register and the input stalls.
// - Reset frees every slot and sets active_slots to 64. Keys are not
//   cleared; a key is only compared while its slot is occupied.
`include "keyed_first_free_slot_allocator_assert.svh"

module keyed_first_free_slot_allocator #(
  parameter int SLOTS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [kffsa_pkg::ACTIVE_W-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic [kffsa_pkg::KEY_W-1:0]        item_key_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic [kffsa_pkg::SLOT_NUM_W-1:0]   slot_number_o
);

  localparam int unsigned NW = kffsa_pkg::SLOT_NUM_W;

  kffsa_pkg::state_e state_q, state_d;

  logic [kffsa_pkg::ACTIVE_W-1:0] active_q;
  logic                           op_q;
  logic [kffsa_pkg::KEY_W-1:0]    key_q;
  logic                           start_q;

  kffsa_pkg::tok_t tok [SLOTS+1];
  kffsa_pkg::tok_t tok_start;
  logic [SLOTS:0]  tok_vld;
  logic [SLOTS-1:0] slot_en;
  kffsa_pkg::cmd_t cmd;

  logic          in_acc, scan_done, res_load;
  logic [1:0]    res_status_d, res_status_q;
  logic [NW-1:0] res_num_d, res_num_q;
  logic          out_vld_q;
  logic [1:0]    out_status_q;
  logic [NW-1:0] out_num_q;

  // Config register: number of slots open to allocation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= kffsa_pkg::ACTIVE_RESET;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      kffsa_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = kffsa_pkg::ST_SCAN;
      end
      kffsa_pkg::ST_SCAN: begin
        if (tok[SLOTS].vld) state_d = kffsa_pkg::ST_RESP;
      end
      kffsa_pkg::ST_RESP: begin
        if (!out_vld_q || !out_stall_i) state_d = kffsa_pkg::ST_IDLE;
      end
      default: state_d = kffsa_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall_o = (state_q != kffsa_pkg::ST_IDLE);
    scan_done  = (state_q == kffsa_pkg::ST_SCAN) && tok[SLOTS].vld;
    res_load   = (state_q == kffsa_pkg::ST_RESP) && (!out_vld_q || !out_stall_i);
  end

  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kffsa_pkg::ST_IDLE;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_acc;
    end
  end

  // Hold the request for the whole search.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= opcode_i;
      key_q <= item_key_i;
    end
  end

  // Launch the token into the first cell in the cycle after acceptance.
  always_comb begin
    tok_start     = '0;
    tok_start.vld = start_q;
  end

  assign tok[0] = tok_start;

  // Row of slot cells; each passes the search token to the next.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign slot_en[i] = 32'(active_q) > 32'(i);

    kffsa_cell #(
      .INDEX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (slot_en[i]),
      .key_i  (key_q),
      .tok_i  (tok[i]),
      .cmd_i  (cmd),
      .tok_o  (tok[i+1])
    );
  end

  for (genvar i = 0; i <= SLOTS; i++) begin : g_vld
    assign tok_vld[i] = tok[i].vld;
  end

  // Decide the outcome from the token leaving the last cell and broadcast
  // the slot update to the row in the same cycle.
  always_comb begin
    cmd          = '0;
    res_status_d = kffsa_pkg::STATUS_OK;
    res_num_d    = '0;
    if (op_q == kffsa_pkg::OP_ALLOC) begin
      if (tok[SLOTS].hit) begin
        res_status_d = kffsa_pkg::STATUS_DUP;
      end else if (tok[SLOTS].free) begin
        res_num_d = tok[SLOTS].free_num;
        cmd.set   = scan_done;
        cmd.num   = tok[SLOTS].free_num;
      end else begin
        res_status_d = kffsa_pkg::STATUS_FULL;
      end
    end else begin
      if (tok[SLOTS].hit) begin
        res_num_d = tok[SLOTS].hit_num;
        cmd.clr   = scan_done;
        cmd.num   = tok[SLOTS].hit_num;
      end else begin
        res_status_d = kffsa_pkg::STATUS_MISSING;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_done) begin
      res_status_q <= res_status_d;
      res_num_q    <= res_num_d;
    end
  end

  // Output register: load when empty or draining, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_status_q <= res_status_q;
      out_num_q    <= res_num_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_status_q;
  assign slot_number_o = out_num_q;

  // A single search token travels the row at any time.
  `KFFSA_ASSERT(a_one_token, clk_i, rst_ni, $countones(tok_vld) <= 1)
  // An update never both claims and frees a slot.
  `KFFSA_NEVER(a_cmd_excl, clk_i, rst_ni, cmd.set && cmd.clr)
  // A successful response names a slot; a failed one names none.
  `KFFSA_ASSERT(a_num_status, clk_i, rst_ni,
                out_vld_q |-> ((out_status_q == kffsa_pkg::STATUS_OK) == (out_num_q != '0)))
  // The input stays stalled from acceptance until the search is resolved.
  `KFFSA_ASSERT(a_stall_scan, clk_i, rst_ni, in_acc |=> in_stall_o)

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the keyed first-free slot allocator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_W        = kffsa_pkg::KEY_W;
  localparam int SLOT_NUM_W   = kffsa_pkg::SLOT_NUM_W;
  localparam int ACTIVE_W     = kffsa_pkg::ACTIVE_W;
  localparam int SLOTS        = 64;
  localparam int CLK_HALF_NS  = 5;
  localparam int RESET_CYCLES = 7;
  // Length of one search, from acceptance up to the next take.
  localparam int SEARCH_CYCLES = SLOTS + 3;
  localparam int POOL_SIZE     = 80;
  localparam int PHASES        = 13;
  localparam int PHASE_ITEMS   = 150;
  localparam int MAX_PRINTED   = 100;

  typedef struct {
    logic                  op;
    logic [KEY_W-1:0]      key;
  } request_t;

  typedef struct {
    logic [1:0]            status;
    logic [SLOT_NUM_W-1:0] slot;
  } response_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PATTERN
  } stall_mode_e;

  // DUT ports; every input starts at a known value.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [ACTIVE_W-1:0]   cfg_wdata_i = kffsa_pkg::ACTIVE_RESET;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic                  opcode_i    = kffsa_pkg::OP_ALLOC;
  logic [KEY_W-1:0]      item_key_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [1:0]            status_o;
  logic [SLOT_NUM_W-1:0] slot_number_o;

  // Shadow of the allocator: occupancy, stored keys and the active count.
  logic                  slot_held [SLOTS];
  logic [KEY_W-1:0]      held_key  [SLOTS];
  logic [ACTIVE_W-1:0]   active_setting;

  request_t              pending_requests[$];
  response_t             expected_responses[$];
  logic [KEY_W-1:0]      key_pool[POOL_SIZE];
  int                    error_count = 0;

  keyed_first_free_slot_allocator #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .item_key_i    (item_key_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .slot_number_o (slot_number_o)
  );

  always #CLK_HALF_NS clk_i = ~clk_i;

  // Count every mismatch; print only the first MAX_PRINTED so a broken block
  // cannot flood the log.
  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("%0t ns mismatch: %s", $time, what);
    end
  endtask

  // Apply one request to the shadow state and return the response the
  // block must produce for it.
  function automatic response_t allocate_or_release(input request_t req);
    response_t rsp;
    int        hit;
    int        limit;
    int        i;
    hit        = -1;
    rsp.status = kffsa_pkg::STATUS_OK;
    rsp.slot   = '0;
    // The duplicate / release search covers every held slot, active or not.
    for (i = 0; i < SLOTS; i++) begin
      if (hit < 0 && slot_held[i] && held_key[i] == req.key) begin
        hit = i;
      end
    end
    if (req.op == kffsa_pkg::OP_ALLOC) begin
      if (hit >= 0) begin
        rsp.status = kffsa_pkg::STATUS_DUP;
      end else begin
        // Counts above the slot total saturate; zero leaves nothing to claim.
        limit      = (int'(active_setting) > SLOTS) ? SLOTS : int'(active_setting);
        rsp.status = kffsa_pkg::STATUS_FULL;
        for (i = 0; i < limit; i++) begin
          if (rsp.status == kffsa_pkg::STATUS_FULL && !slot_held[i]) begin
            slot_held[i] = 1'b1;
            held_key[i]  = req.key;
            rsp.status   = kffsa_pkg::STATUS_OK;
            rsp.slot     = SLOT_NUM_W'(i + 1);
          end
        end
      end
    end else begin
      if (hit < 0) begin
        rsp.status = kffsa_pkg::STATUS_MISSING;
      end else begin
        slot_held[hit] = 1'b0;
        rsp.slot       = SLOT_NUM_W'(hit + 1);
      end
    end
    return rsp;
  endfunction

  // Request driver: bursts of back-to-back items separated by random gaps.
  // Hold the payload while stalled; predict each item as it is accepted.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    request_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        nxt.op  = opcode_i;
        nxt.key = item_key_i;
        expected_responses.push_back(allocate_or_release(nxt));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          nxt = pending_requests.pop_front();
          opcode_i   <= nxt.op;
          item_key_i <= nxt.key;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            // End the burst; some bursts run straight into the next one.
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Response stall generator: modes change at random intervals, and
  // a long hold-off now and then lets the block fill up and stall its input.
  int          stall_cycle = 0;
  int          hold_left   = 0;
  int          mode_left   = 0;
  stall_mode_e stall_mode  = STALL_NONE;
  logic [7:0]  stall_bits  = '0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_stall
    logic stall;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_cycle++;
      if (stall_cycle % 40000 == 15000) begin
        hold_left = 700;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(64, 600);
        stall_bits = 8'($urandom);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:    stall = 1'b0;
          STALL_LIGHT:   stall = ($urandom_range(0, 3) == 0);
          STALL_HEAVY:   stall = ($urandom_range(0, 3) != 0);
          default:       stall = stall_bits[stall_cycle % 8];
        endcase
      end
      out_stall_i <= stall;
    end
  end

  // Response monitor: compare every accepted result with the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin : check_responses
    response_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_responses.size() == 0) begin
        report_mismatch($sformatf("response with nothing expected: status %0d slot %0d",
                                  status_o, slot_number_o));
      end else begin
        want = expected_responses.pop_front();
        if (status_o !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        end
        if (slot_number_o !== want.slot) begin
          report_mismatch($sformatf("slot %0d, expected %0d", slot_number_o, want.slot));
        end
      end
    end
  end

  task automatic queue_request(input logic op, input logic [KEY_W-1:0] key);
    request_t req;
    req.op  = op;
    req.key = key;
    pending_requests.push_back(req);
  endtask

  // Sample on the falling edge so the check never races the driver.
  task automatic wait_until_drained();
    @(negedge clk_i);
    while (pending_requests.size() > 0 || in_valid_i || expected_responses.size() > 0) begin
      @(negedge clk_i);
    end
  endtask

  // Write the active count only with the block idle.
  task automatic write_active_slots(input logic [ACTIVE_W-1:0] value);
    wait_until_drained();
    repeat (4) @(posedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    active_setting = value;
  endtask

  // Draw mostly from a window of the pool a little larger than the active
  // count, so allocations can run the slots full and releases mostly hit.
  // The whole pool frees keys stranded beyond a shrunken active count;
  // fresh keys only ever go to releases, so none get stranded.
  task automatic queue_random_requests(input int count, input int alloc_pct);
    request_t req;
    int       window;
    int       pick;
    int       k;
    window = ((int'(active_setting) > SLOTS) ? SLOTS : int'(active_setting)) + 8;
    if (window > POOL_SIZE) begin
      window = POOL_SIZE;
    end
    for (k = 0; k < count; k++) begin
      req.op = ($urandom_range(0, 99) < alloc_pct) ? kffsa_pkg::OP_ALLOC
                                                    : kffsa_pkg::OP_RELEASE;
      pick   = $urandom_range(0, 99);
      if (pick < 80) begin
        req.key = key_pool[$urandom_range(0, window - 1)];
      end else if (pick < 95) begin
        req.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        req.op  = kffsa_pkg::OP_RELEASE;
        req.key = {$urandom, $urandom};
      end
      pending_requests.push_back(req);
    end
  endtask

  // Stimulus: directed corners first, then random phases under a range of
  // active counts, each phase draining before the next write.
  logic [ACTIVE_W-1:0] phase_active[PHASES] = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd2, 7'd65,
                                                7'd64, 7'd40, 7'd0, 7'd127, 7'd3, 7'd0,
                                                7'd64};
  int                  phase_alloc[PHASES]  = '{80, 70, 50, 50, 60, 80, 40, 60, 55, 75,
                                                50, 60, 30};

  initial begin : run_stimulus
    int p;
    int i;
    active_setting = kffsa_pkg::ACTIVE_RESET;
    for (i = 0; i < SLOTS; i++) begin
      slot_held[i] = 1'b0;
      held_key[i]  = '0;
    end
    // Pool holds both all-zero and all-one keys plus near neighbors that
    // differ from another key in a single bit.
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < POOL_SIZE; i++) begin
      if (i % 5 == 0) begin
        key_pool[i] = key_pool[i - 1] ^ (64'h1 << $urandom_range(0, 63));
      end else begin
        key_pool[i] = {$urandom, $urandom};
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset count of 64: allocate, duplicate, miss, release, lowest-free reuse.
    queue_request(kffsa_pkg::OP_ALLOC,   64'h0);
    queue_request(kffsa_pkg::OP_ALLOC,   '1);
    queue_request(kffsa_pkg::OP_ALLOC,   64'h0);
    queue_request(kffsa_pkg::OP_RELEASE, 64'h1);
    queue_request(kffsa_pkg::OP_RELEASE, '1);
    queue_request(kffsa_pkg::OP_ALLOC,   64'h8000_0000_0000_0000);
    queue_request(kffsa_pkg::OP_ALLOC,   64'h1);
    queue_request(kffsa_pkg::OP_RELEASE, 64'h0);
    queue_request(kffsa_pkg::OP_ALLOC,   64'h5555_5555_5555_5555);
    // Zero active slots: new keys are full, keys still held are duplicates
    // and can be released.
    write_active_slots(7'd0);
    queue_request(kffsa_pkg::OP_ALLOC,   64'hAAAA_AAAA_AAAA_AAAA);
    queue_request(kffsa_pkg::OP_ALLOC,   64'h1);
    queue_request(kffsa_pkg::OP_RELEASE, 64'h1);
    // One active slot, busy then freed.
    write_active_slots(7'd1);
    queue_request(kffsa_pkg::OP_ALLOC,   64'h0123_4567_89AB_CDEF);
    queue_request(kffsa_pkg::OP_RELEASE, 64'h5555_5555_5555_5555);
    queue_request(kffsa_pkg::OP_ALLOC,   64'h0123_4567_89AB_CDEF);
    // Count above the slot total saturates.
    write_active_slots(7'd127);
    queue_request(kffsa_pkg::OP_ALLOC,   64'hFEDC_BA98_7654_3210);
    queue_request(kffsa_pkg::OP_RELEASE, 64'h8000_0000_0000_0000);
    queue_request(kffsa_pkg::OP_RELEASE, 64'h0123_4567_89AB_CDEF);
    queue_request(kffsa_pkg::OP_RELEASE, 64'hFEDC_BA98_7654_3210);

    for (p = 0; p < PHASES; p++) begin
      // Zero entries in the list stand for a random count after the first.
      if (phase_active[p] == 7'd0 && p > 3) begin
        write_active_slots(ACTIVE_W'($urandom_range(0, 127)));
      end else begin
        write_active_slots(phase_active[p]);
      end
      queue_random_requests(PHASE_ITEMS, phase_alloc[p]);
    end

    wait_until_drained();
    repeat (SEARCH_CYCLES) @(posedge clk_i);
    if (expected_responses.size() > 0) begin
      report_mismatch($sformatf("%0d responses never arrived", expected_responses.size()));
    end
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #25_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
